>>> hw/rtl/plafk_pkg.sv
// ---------------------------------------------------------------------------
// plafk_pkg
// Types, register indexes and CORDIC constants for the planar arm
// forward kinematics pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package plafk_pkg;

    localparam int NUM_LANES    = 4;   // one lane per length register
    localparam int CORDIC_STEPS = 16;
    localparam int ZW           = 26;  // CORDIC datapath width, Q2.22 plus headroom
    localparam int TRIG_W       = 16;  // Q1.14 sine and cosine
    localparam int POS_W        = 20;

    localparam logic signed [ZW-1:0] CORDIC_START = ZW'(2547004);
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(1 << 22);
    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(1 << 23);

    localparam logic signed [ZW-1:0] ATAN_UNITS [CORDIC_STEPS] = '{
        ZW'(2097152), ZW'(1238021), ZW'(654136), ZW'(332050),
        ZW'(166669),  ZW'(83416),   ZW'(41718),  ZW'(20860),
        ZW'(10430),   ZW'(5215),    ZW'(2608),   ZW'(1304),
        ZW'(652),     ZW'(326),     ZW'(163),    ZW'(81)
    };

    typedef enum logic [2:0] {
        CFG_NUM_LINKS = 3'd0,
        CFG_BASE_X    = 3'd1,
        CFG_BASE_Y    = 3'd2,
        CFG_LEN_LINK0 = 3'd3,
        CFG_LEN_LINK1 = 3'd4,
        CFG_LEN_LINK2 = 3'd5,
        CFG_LEN_LINK3 = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] angle0;
        logic [15:0] angle1;
        logic [15:0] angle2;
        logic [15:0] angle3;
        logic [2:0]  which_joint;
    } item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } result_t;

    typedef struct packed {
        logic signed [ZW-1:0] x;
        logic signed [ZW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_lane_t;

    // per-item sideband that rides beside the CORDIC lanes
    typedef struct packed {
        logic [NUM_LANES-1:0] flip;
        logic [NUM_LANES-1:0] mask;
    } side_t;

    // one CORDIC rotation step; shifts floor toward minus infinity
    function automatic cordic_lane_t cordic_rot(cordic_lane_t a, int unsigned step);
        cordic_lane_t         r;
        logic signed [ZW-1:0] dx;
        logic signed [ZW-1:0] dy;
        dx = a.y >>> step;
        dy = a.x >>> step;
        if (!a.z[ZW-1])
        begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - ATAN_UNITS[step];
        end
        else
        begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + ATAN_UNITS[step];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/plafk_cordic_stage.sv
// ---------------------------------------------------------------------------
// plafk_cordic_stage
// One register stage of the CORDIC pipeline: two rotation steps on every lane.
// ---------------------------------------------------------------------------
`default_nettype none

module plafk_cordic_stage
    import plafk_pkg::*;
#(
    parameter int FIRST_STEP = 0
)
(
    input  wire logic         clk,
    input  wire logic         en,
    input  wire cordic_lane_t lanes     [NUM_LANES],
    output cordic_lane_t      lanes_reg [NUM_LANES]
);

    cordic_lane_t lanes_next [NUM_LANES];

    // rotate twice per lane
    always_comb
    begin
        for (int j = 0; j < NUM_LANES; j++)
        begin
            lanes_next[j] = cordic_rot(cordic_rot(lanes[j], FIRST_STEP), FIRST_STEP + 1);
        end
    end

    // advance when the stage moves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/planar_arm_forward_kinematics.sv
// Throughput: one item per cycle; every stage advances independently, so a
// stalled result blocks input only once all 12 stages hold items.
// The stage count is set by the 16-step CORDIC, two steps per register stage.
// Reset clears all valid bits and loads the register defaults
// (num_links 2, base 0, each link length 1.0).
// ---------------------------------------------------------------------------
// planar_arm_forward_kinematics
// Pipelined planar serial arm forward kinematics: cumulative joint angles,
// CORDIC sine and cosine per link, length products, sum plus base.
// ---------------------------------------------------------------------------
`default_nettype none

module planar_arm_forward_kinematics
    import plafk_pkg::*;
#(
    parameter int MAX_LINKS  = 4,
    parameter int ANGLE_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire item_t       item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_t          result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int NSTG         = CORDIC_STEPS / 2 + 4;
    localparam int NCOR         = CORDIC_STEPS / 2;
    localparam int LINK_CAP     = (MAX_LINKS < NUM_LANES) ? MAX_LINKS : NUM_LANES;
    localparam int IN_BITS      = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
    localparam int PHASE_SHIFT  = 24 - ANGLE_BITS;
    localparam int ACC_W        = 35;

    // configuration registers
    logic [2:0]         num_links_reg;
    logic signed [15:0] base_x_reg;
    logic signed [15:0] base_y_reg;
    logic [15:0]        len_reg [NUM_LANES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_links_reg <= 3'd2;
            base_x_reg    <= '0;
            base_y_reg    <= '0;
            for (int j = 0; j < NUM_LANES; j++)
            begin
                len_reg[j] <= 16'd256;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NUM_LINKS: num_links_reg <= cfg_data[2:0];
                CFG_BASE_X:    base_x_reg    <= cfg_data;
                CFG_BASE_Y:    base_y_reg    <= cfg_data;
                CFG_LEN_LINK0: len_reg[0]    <= cfg_data;
                CFG_LEN_LINK1: len_reg[1]    <= cfg_data;
                CFG_LEN_LINK2: len_reg[2]    <= cfg_data;
                CFG_LEN_LINK3: len_reg[3]    <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and the per-stage advance chain
    logic [NSTG:1] v_reg;
    logic [NSTG:1] v_next;
    logic [NSTG:1] en;

    always_comb
    begin
        en[NSTG] = !v_reg[NSTG] || !result_stall;
        for (int s = NSTG - 1; s >= 1; s--)
        begin
            en[s] = !v_reg[s] || en[s + 1];
        end
        if (en[1])
        begin
            v_next[1] = item_valid;
        end
        else
        begin
            v_next[1] = v_reg[1];
        end
        for (int s = 2; s <= NSTG; s++)
        begin
            if (en[s])
            begin
                v_next[s] = v_reg[s - 1];
            end
            else
            begin
                v_next[s] = v_reg[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign item_stall   = !en[1];
    assign result_valid = v_reg[NSTG];

    // stage 1: cumulative angles, quarter-turn fold, lane mask
    logic [ANGLE_BITS-1:0] ang_in [NUM_LANES];
    logic [ANGLE_BITS-1:0] cum    [NUM_LANES];
    logic [2:0]            links;
    logic [2:0]            k;
    cordic_lane_t          lane1_next [NUM_LANES];
    side_t                 side1_next;

    assign ang_in[0] = ANGLE_BITS'(item.angle0[IN_BITS-1:0]);
    assign ang_in[1] = ANGLE_BITS'(item.angle1[IN_BITS-1:0]);
    assign ang_in[2] = ANGLE_BITS'(item.angle2[IN_BITS-1:0]);
    assign ang_in[3] = ANGLE_BITS'(item.angle3[IN_BITS-1:0]);

    always_comb
    begin
        logic [23:0]          ph;
        logic signed [ZW-1:0] z;
        links = (num_links_reg > 3'(LINK_CAP)) ? 3'(LINK_CAP) : num_links_reg;
        k     = (item.which_joint > links) ? links : item.which_joint;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            cum[j] = (j == 0) ? ang_in[0] : cum[(j == 0) ? 0 : j - 1] + ang_in[j];
            ph     = 24'(cum[j]) << PHASE_SHIFT;
            z      = ZW'(signed'(ph));
            side1_next.flip[j] = 1'b0;
            if (z >= QUARTER_TURN)
            begin
                z = z - HALF_TURN;
                side1_next.flip[j] = 1'b1;
            end
            else if (z < -QUARTER_TURN)
            begin
                z = z + HALF_TURN;
                side1_next.flip[j] = 1'b1;
            end
            lane1_next[j].x    = CORDIC_START;
            lane1_next[j].y    = '0;
            lane1_next[j].z    = z;
            side1_next.mask[j] = (3'(j) < k);
        end
    end

    cordic_lane_t lane_pipe [NCOR+1][NUM_LANES];
    side_t        side_reg  [1:NSTG-3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            lane_pipe[0] <= lane1_next;
            side_reg[1]  <= side1_next;
        end
        for (int s = 2; s <= NSTG - 3; s++)
        begin
            if (en[s])
            begin
                side_reg[s] <= side_reg[s - 1];
            end
        end
    end

    // stages 2 to NCOR+1: CORDIC rotations
    for (genvar g = 0; g < NCOR; g++)
    begin : g_cordic
        plafk_cordic_stage #(
            .FIRST_STEP (2 * g)
        ) u_stage (
            .clk       (clk),
            .en        (en[g + 2]),
            .lanes     (lane_pipe[g]),
            .lanes_reg (lane_pipe[g + 1])
        );
    end

    // stage NSTG-2: round to Q1.14, clamp, undo the fold
    logic signed [TRIG_W-1:0] c_reg [NUM_LANES];
    logic signed [TRIG_W-1:0] s_reg [NUM_LANES];
    logic signed [TRIG_W-1:0] c_next [NUM_LANES];
    logic signed [TRIG_W-1:0] s_next [NUM_LANES];

    function automatic logic signed [TRIG_W-1:0] round_trig(logic signed [ZW-1:0] v,
                                                           logic flip);
        logic signed [ZW-1:0]     r;
        logic signed [TRIG_W-1:0] t;
        r = (v + ZW'(128)) >>> 8;
        if (r > ZW'(16384))
        begin
            t = TRIG_W'(16384);
        end
        else if (r < -ZW'(16384))
        begin
            t = -TRIG_W'(16384);
        end
        else
        begin
            t = r[TRIG_W-1:0];
        end
        return flip ? -t : t;
    endfunction

    always_comb
    begin
        for (int j = 0; j < NUM_LANES; j++)
        begin
            c_next[j] = round_trig(lane_pipe[NCOR][j].x, side_reg[NSTG-3].flip[j]);
            s_next[j] = round_trig(lane_pipe[NCOR][j].y, side_reg[NSTG-3].flip[j]);
        end
    end

    logic [NUM_LANES-1:0] mask_reg;

    always_ff @(posedge clk)
    begin
        if (en[NSTG-2])
        begin
            c_reg    <= c_next;
            s_reg    <= s_next;
            mask_reg <= side_reg[NSTG-3].mask;
        end
    end

    // stage NSTG-1: link length products, masked past the asked joint
    logic signed [32:0] px_reg [NUM_LANES];
    logic signed [32:0] py_reg [NUM_LANES];

    always_ff @(posedge clk)
    begin
        if (en[NSTG-1])
        begin
            for (int j = 0; j < NUM_LANES; j++)
            begin
                if (mask_reg[j])
                begin
                    px_reg[j] <= signed'({1'b0, len_reg[j]}) * c_reg[j];
                    py_reg[j] <= signed'({1'b0, len_reg[j]}) * s_reg[j];
                end
                else
                begin
                    px_reg[j] <= '0;
                    py_reg[j] <= '0;
                end
            end
        end
    end

    // output stage: sum, round to Q11.8, add base, saturate
    function automatic logic signed [POS_W-1:0] finish(logic signed [ACC_W-1:0] acc,
                                                      logic signed [15:0] base);
        logic signed [ACC_W-1:0] t;
        logic signed [21:0]      p;
        t = (acc + ACC_W'(8192)) >>> 14;
        p = 22'(base) + t[21:0];
        if (p > 22'sd524287)
        begin
            return POS_W'(524287);
        end
        else if (p < -22'sd524288)
        begin
            return POS_W'(-524288);
        end
        return p[POS_W-1:0];
    endfunction

    result_t result_reg;
    result_t result_next;

    always_comb
    begin
        logic signed [ACC_W-1:0] ax;
        logic signed [ACC_W-1:0] ay;
        ax = '0;
        ay = '0;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            ax = ax + ACC_W'(px_reg[j]);
            ay = ay + ACC_W'(py_reg[j]);
        end
        result_next.pos_x = finish(ax, base_x_reg);
        result_next.pos_y = finish(ay, base_y_reg);
    end

    // hold the beat while stalled
    always_ff @(posedge clk)
    begin
        if (en[NSTG])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> hw/rtl/plafk_checker.sv
// ---------------------------------------------------------------------------
// plafk_checker
// Port-level checks on the kinematics pipeline, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module plafk_checker
    import plafk_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_stall,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // input backs up only when the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without a blocked result");

    // a freshly drained pipeline takes input
    a_drain_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!result_valid) && !result_valid |-> !item_stall)
        else $error("input stalled with an empty output stage");

    // handshake lines are always driven out of reset
    a_flags_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({item_valid, item_stall, result_valid, result_stall}))
        else $error("handshake line unknown");

endmodule

bind planar_arm_forward_kinematics plafk_checker u_plafk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Planar arm forward kinematics testbench
// Drives joint angle sets through the pipeline under several link and base
// settings, predicts each joint position with a local CORDIC model and
// compares every result beat in order. Both sides idle at random, and the
// result side holds off long enough once to back the pipeline up.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    import plafk_pkg::*;

    localparam int        PIPE_DEPTH  = 12;
    localparam int        CYCLE_LIMIT = 400000;
    localparam int        PHASES      = 10;
    localparam int        PER_PHASE   = 153;
    localparam logic [2:0] CFG_UNUSED = 3'd7;   // index past the register list
    localparam longint    HALF_UNITS  = 64'sd1 << 23;
    localparam longint    QTR_UNITS   = 64'sd1 << 22;
    localparam longint    ROT_ATAN [16] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    typedef struct {
        item_t   stim;
        bit      known;
        result_t pose;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // arm settings as seen by the predictor
    logic [2:0]  arm_links;
    logic [15:0] arm_base_x;
    logic [15:0] arm_base_y;
    logic [15:0] arm_len [4];

    result_t     pose_queue[$];
    int          mismatches;
    int          poses_checked;
    int          cycles;
    int          phase_no;
    bit          calm;
    bit          hold_done;
    int          hold_left;

    planar_arm_forward_kinematics i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cosine and sine in Q1.14 of a 16-bit turn fraction
    function automatic void joint_trig(input logic [15:0] ang, output longint c,
                                       output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z    = longint'({ang, 8'h00});
        x    = 2547004;
        y    = 0;
        flip = 1'b0;
        if (z >= HALF_UNITS)
            z -= 2 * HALF_UNITS;
        if (z >= QTR_UNITS)
        begin
            z   -= HALF_UNITS;
            flip = 1'b1;
        end
        else if (z < -QTR_UNITS)
        begin
            z   += HALF_UNITS;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ROT_ATAN[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ROT_ATAN[i];
            end
        end
        x = (x + 128) >>> 8;
        y = (y + 128) >>> 8;
        x = (x > 16384) ? 16384 : ((x < -16384) ? -16384 : x);
        y = (y > 16384) ? 16384 : ((y < -16384) ? -16384 : y);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint clamp_pos(input longint v);
        return (v > 524287) ? 524287 : ((v < -524288) ? -524288 : v);
    endfunction

    // position of the joint asked for, under the current arm settings
    function automatic result_t arm_pose(input item_t it);
        logic [15:0] ang [4];
        logic [15:0] cum;
        int          links;
        int          k;
        longint      c;
        longint      s;
        longint      acc_x;
        longint      acc_y;
        result_t     r;
        ang   = '{it.angle0, it.angle1, it.angle2, it.angle3};
        links = (arm_links > 4) ? 4 : int'(arm_links);
        k     = (int'(it.which_joint) > links) ? links : int'(it.which_joint);
        cum   = '0;
        acc_x = 0;
        acc_y = 0;
        for (int j = 0; j < k; j++)
        begin
            cum = cum + ang[j];
            joint_trig(cum, c, s);
            acc_x += longint'(arm_len[j]) * c;
            acc_y += longint'(arm_len[j]) * s;
        end
        r.pos_x = POS_W'(clamp_pos(longint'($signed(arm_base_x)) + ((acc_x + 8192) >>> 14)));
        r.pos_y = POS_W'(clamp_pos(longint'($signed(arm_base_y)) + ((acc_y + 8192) >>> 14)));
        return r;
    endfunction

    task automatic report(input string what, input logic [POS_W-1:0] got,
                          input logic [POS_W-1:0] want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
                 what, $signed(got), $signed(want), cycles);
        mismatches++;
    endtask

    // one register write; valid stays high for a following write
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_NUM_LINKS: arm_links  = val[2:0];
            CFG_BASE_X:    arm_base_x = val;
            CFG_BASE_Y:    arm_base_y = val;
            CFG_LEN_LINK0: arm_len[0] = val;
            CFG_LEN_LINK1: arm_len[1] = val;
            CFG_LEN_LINK2: arm_len[2] = val;
            CFG_LEN_LINK3: arm_len[3] = val;
            default: ;
        endcase
    endtask

    task automatic setup_arm(input logic [15:0] links, input logic [15:0] bx,
                             input logic [15:0] by, input logic [15:0] l0,
                             input logic [15:0] l1, input logic [15:0] l2,
                             input logic [15:0] l3);
        write_reg(CFG_NUM_LINKS, links);
        write_reg(CFG_BASE_X, bx);
        write_reg(CFG_BASE_Y, by);
        write_reg(CFG_LEN_LINK0, l0);
        write_reg(CFG_LEN_LINK1, l1);
        write_reg(CFG_LEN_LINK2, l2);
        write_reg(CFG_LEN_LINK3, l3);
        write_reg(CFG_UNUSED, 16'hFFFF);
        cfg_valid <= 1'b0;
    endtask

    // offer one beat after an optional idle gap, record the expected pose
    task automatic send_pose(input item_t it);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 36)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall);
        pose_queue.insert(pose_queue.size(), arm_pose(it));
    endtask

    function automatic item_t random_pose();
        item_t it;
        it.angle0      = 16'($urandom);
        it.angle1      = 16'($urandom);
        it.angle2      = 16'($urandom);
        it.angle3      = 16'($urandom);
        it.which_joint = 3'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic drain();
        while (pose_queue.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    // result side: random hold-off, one long hold in the pressure phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (phase_no == 3 && !hold_done)
        begin
            hold_done    <= 1'b1;
            hold_left    <= 80;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= !calm && ($urandom_range(0, 99) < 36);
    end

    // check each result beat against the oldest expected pose
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pose_queue.size() == 0)
            begin
                $display("UNEXPECTED result beat at cycle %0d", cycles);
                mismatches++;
            end
            else
            begin
                if (result.pos_x !== pose_queue[0].pos_x)
                    report("pos_x", result.pos_x, pose_queue[0].pos_x);
                if (result.pos_y !== pose_queue[0].pos_y)
                    report("pos_y", result.pos_y, pose_queue[0].pos_y);
                void'(pose_queue.pop_front());
                poses_checked++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d poses outstanding",
                     cycles, pose_queue.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t table_rows [$];
        stim_row_t row;
        result_t   want;

        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cycles      = 0;
        mismatches  = 0;
        poses_checked = 0;
        phase_no    = 0;
        calm        = 1'b0;
        arm_links   = 3'd2;
        arm_base_x  = '0;
        arm_base_y  = '0;
        arm_len     = '{16'd256, 16'd256, 16'd256, 16'd256};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under reset settings; base joint is known exactly
        table_rows = '{
            '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd0}, 1'b1, '{20'sd0, 20'sd0}},
            '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd0}, 1'b1, '{20'sd0, 20'sd0}},
            '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd1}, 1'b0, '{20'sd0, 20'sd0}},
            '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd2}, 1'b0, '{20'sd0, 20'sd0}},
            '{'{16'h4000, 16'h0000, 16'h0000, 16'h0000, 3'd2}, 1'b0, '{20'sd0, 20'sd0}},
            '{'{16'h8000, 16'h4000, 16'h0000, 16'h0000, 3'd2}, 1'b0, '{20'sd0, 20'sd0}},
            '{'{16'hC000, 16'hC000, 16'h0000, 16'h0000, 3'd1}, 1'b0, '{20'sd0, 20'sd0}},
            '{'{16'h2000, 16'hE000, 16'h0000, 16'h0000, 3'd2}, 1'b0, '{20'sd0, 20'sd0}},
            '{'{16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 3'd2}, 1'b0, '{20'sd0, 20'sd0}},
            '{'{16'h3FFF, 16'h4001, 16'h7FFF, 16'h8001, 3'd3}, 1'b0, '{20'sd0, 20'sd0}},
            '{'{16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 3'd4}, 1'b0, '{20'sd0, 20'sd0}},
            '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7}, 1'b0, '{20'sd0, 20'sd0}},
            '{'{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 3'd5}, 1'b0, '{20'sd0, 20'sd0}}
        };
        foreach (table_rows[i])
        begin
            row = table_rows[i];
            want = arm_pose(row.stim);
            if (row.known && want.pos_x !== row.pose.pos_x)
                report("table pos_x", want.pos_x, row.pose.pos_x);
            if (row.known && want.pos_y !== row.pose.pos_y)
                report("table pos_y", want.pos_y, row.pose.pos_y);
            send_pose(row.stim);
        end
        item_valid <= 1'b0;
        drain();

        // random phases, each under its own arm settings
        for (int p = 1; p <= PHASES; p++)
        begin
            case (p)
                1: setup_arm(16'd4, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF);
                2: setup_arm(16'd4, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF);
                3: setup_arm(16'd3, 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom));
                4: setup_arm(16'd0, 16'h1234, 16'hEDCB, 16'd256, 16'd256,
                             16'd256, 16'd256);
                5: setup_arm(16'd1, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
                             16'h0000, 16'h0000);
                6: setup_arm(16'd7, 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom));
                7: setup_arm(16'hFFFC, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, 16'h0000);
                default: setup_arm(16'($urandom_range(1, 4)), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
            endcase
            phase_no = p;
            calm     = (p == 2);
            for (int n = 0; n < PER_PHASE; n++)
                send_pose(random_pose());
            item_valid <= 1'b0;
            calm = 1'b0;
            drain();
        end

        $display("Covered %0d poses over %0d arm settings, extremes and backpressure included",
                 poses_checked, PHASES + 1);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/plafk_pkg.sv
hw/rtl/plafk_cordic_stage.sv
hw/rtl/planar_arm_forward_kinematics.sv
hw/rtl/plafk_checker.sv
verif/testbench.sv
